[sv/bwc_pkg.sv]
// Package with shared types and constants for the weak block checksum.
`timescale 1ns / 1ps
package bwc_pkg;

  localparam int MODULUS_DEFAULT = 65536;
  localparam logic [15:0] BLOCK_LENGTH_RESET = 16'd1024;
  localparam logic [15:0] COUNT_CEILING = 16'hFFFF;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

  typedef struct packed {
    logic signed [7:0] data_byte;
    logic              end_of_stream;
  } in_word_t;

  typedef struct packed {
    logic [31:0] checksum;
    logic [15:0] block_bytes;
  } out_word_t;

  typedef struct packed {
    logic valid;
    logic full;
  } queue_status_t;

endpackage

[sv/bwc_front.sv]
// Front stage: accepts input words and turns each byte into its residue.
`timescale 1ns / 1ps
module bwc_front
  import bwc_pkg::*;
#(
  parameter int MODULUS = MODULUS_DEFAULT,
  parameter int SUM_W   = $clog2(MODULUS)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_word,
  input  queue_status_t    q_status,
  output logic             q_push,
  output logic [SUM_W:0]   q_item
);

  logic [SUM_W-1:0] res_table [256];
  logic             f_valid;
  logic [SUM_W-1:0] f_residue;
  logic             f_last;
  logic             accept;
  logic [7:0]       byte_index;

  for (genvar i = 0; i < 256; i++) begin : g_res
    localparam int SIGNED_VAL = (i >= 128) ? (i - 256) : i;
    localparam int RES = ((SIGNED_VAL % MODULUS) + MODULUS) % MODULUS;
    assign res_table[i] = SUM_W'(RES);
  end

  assign byte_index = $unsigned(in_word.data_byte);
  assign in_ready   = !f_valid || !q_status.full;
  assign accept     = in_valid && in_ready;
  assign q_push     = f_valid && !q_status.full;
  assign q_item     = {f_last, f_residue};

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (q_push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_residue <= res_table[byte_index];
      f_last    <= in_word.end_of_stream;
    end
  end

endmodule

[sv/bwc_queue.sv]
// Two-entry queue between the front and back stages.
`timescale 1ns / 1ps
module bwc_queue
  import bwc_pkg::*;
#(
  parameter int WIDTH = 17
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output queue_status_t    status
);

  logic [WIDTH-1:0]       entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  assign status.valid = (count != '0);
  assign status.full  = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign pop_data     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

[sv/bwc_back.sv]
// Back stage: accumulates the two sums per block and forms the checksum word.
`timescale 1ns / 1ps
module bwc_back
  import bwc_pkg::*;
#(
  parameter int MODULUS = MODULUS_DEFAULT,
  parameter int SUM_W   = $clog2(MODULUS)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [15:0]    block_length,
  input  queue_status_t  q_status,
  input  logic [SUM_W:0] q_item,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output out_word_t      out_word
);

  localparam logic [SUM_W:0] MOD_X  = (SUM_W + 1)'(MODULUS);
  localparam logic [31:0]    MOD_32 = 32'(MODULUS);

  logic [SUM_W-1:0] sum_a;
  logic [SUM_W-1:0] sum_b;
  logic [15:0]      bytes_in_block;
  logic             mid_valid;
  logic [SUM_W-1:0] mid_a;
  logic [SUM_W-1:0] mid_b;
  logic [15:0]      mid_count;

  logic [SUM_W-1:0] residue;
  logic             last;
  logic [SUM_W:0]   a_sum;
  logic [SUM_W-1:0] a_next;
  logic [SUM_W:0]   b_sum;
  logic [SUM_W-1:0] b_next;
  logic [15:0]      count_next;
  logic [15:0]      limit;
  logic             close;
  logic             out_load;
  logic             mid_move;
  logic             mid_free;

  assign residue = q_item[SUM_W-1:0];
  assign last    = q_item[SUM_W];

  always_comb begin
    a_sum  = {1'b0, sum_a} + {1'b0, residue};
    a_next = (a_sum >= MOD_X) ? SUM_W'(a_sum - MOD_X) : a_sum[SUM_W-1:0];
    b_sum  = {1'b0, sum_b} + {1'b0, a_next};
    b_next = (b_sum >= MOD_X) ? SUM_W'(b_sum - MOD_X) : b_sum[SUM_W-1:0];
    count_next = bytes_in_block + 16'd1;
    limit  = (block_length == 16'd0) ? 16'd1 : block_length;
    close  = last || (count_next >= limit) || (count_next == COUNT_CEILING);
  end

  assign out_load = !out_valid || out_ready;
  assign mid_move = mid_valid && out_load;
  assign mid_free = !mid_valid || mid_move;
  assign q_pop    = q_status.valid && mid_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_a          <= '0;
      sum_b          <= '0;
      bytes_in_block <= '0;
      mid_valid      <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (q_pop) begin
        if (close) begin
          sum_a          <= '0;
          sum_b          <= '0;
          bytes_in_block <= '0;
        end else begin
          sum_a          <= a_next;
          sum_b          <= b_next;
          bytes_in_block <= count_next;
        end
      end
      if (q_pop && close) begin
        mid_valid <= 1'b1;
      end else if (mid_move) begin
        mid_valid <= 1'b0;
      end
      if (mid_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && close) begin
      mid_a     <= a_next;
      mid_b     <= b_next;
      mid_count <= count_next;
    end
    if (mid_move) begin
      out_word.checksum    <= 32'(mid_a) + 32'(mid_b) * MOD_32;
      out_word.block_bytes <= mid_count;
    end
  end

endmodule

[sv/block_weak_checksum.sv]
// Top level of the weak block checksum engine.
//
// A signed byte stream enters on in_valid/in_ready, one word per cycle at
// most; each word carries a byte and an end-of-stream flag. The stream is
// cut into blocks of block_length bytes, and the last block may be shorter
// when a word carries the end-of-stream flag. A length of zero acts as one.
// For every closed block one output word appears on out_valid/out_ready
// with the checksum and the byte count of the block.
// The block length register is written on cfg_valid/cfg_ready, which is
// always ready, and should only change while no block is open.
// The engine takes one byte per cycle when the receiver keeps up. A word
// that closes a block passes the input register, one slot of the
// two-entry queue and the accumulator stage, and the output register then
// forms the checksum and raises out_valid.
// When the receiver stalls, the accumulator stage holds the next closed
// block, then the queue and the input register fill and in_ready falls.
// Reset clears the sums, the byte count and all valid flags, and sets the
// block length to 1024.
`timescale 1ns / 1ps
module block_weak_checksum
  import bwc_pkg::*;
#(
  parameter int MODULUS = MODULUS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int SUM_W = $clog2(MODULUS);

  logic [15:0]    block_length;
  logic [15:0]    limit;
  queue_status_t  q_status;
  logic           q_push;
  logic           q_pop;
  logic [SUM_W:0] q_push_item;
  logic [SUM_W:0] q_pop_item;

  assign cfg_ready = 1'b1;
  assign limit     = (block_length == 16'd0) ? 16'd1 : block_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_length <= BLOCK_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      block_length <= cfg_data;
    end
  end

  bwc_front #(
    .MODULUS(MODULUS),
    .SUM_W  (SUM_W)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_word (in_word),
    .q_status(q_status),
    .q_push  (q_push),
    .q_item  (q_push_item)
  );

  bwc_queue #(
    .WIDTH(SUM_W + 1)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_push_item),
    .pop      (q_pop),
    .pop_data (q_pop_item),
    .status   (q_status)
  );

  bwc_back #(
    .MODULUS(MODULUS),
    .SUM_W  (SUM_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .block_length(block_length),
    .q_status    (q_status),
    .q_item      (q_pop_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_word    (out_word)
  );

  a_bytes_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word.block_bytes != 16'd0)
    else $error("Output word covers no bytes.");

  a_bytes_in_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word.block_bytes <= limit)
    else $error("Output word covers more bytes than the block length.");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Output valid after reset.");

  a_pop_has_data: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_status.valid)
    else $error("Queue popped while empty.");

endmodule
